@@ design/gaf_pkg.sv @@
// shared constants and types for the genotype allele frequency core
`default_nettype none

package gaf_pkg;

    localparam int FRAC_BITS = 16;
    localparam int COUNT_W   = 17;
    localparam int FREQ_W    = FRAC_BITS + 1;
    localparam int NUM_W     = COUNT_W + 2;
    localparam int DEN_W     = COUNT_W + 1;
    localparam int PROD_W    = 2 * FREQ_W;
    localparam int TERM_W    = PROD_W - (FRAC_BITS - 1);
    localparam int ACC_W     = 64;
    localparam int SUM_W     = 32;
    localparam int GENO_W    = 3;
    localparam int STEP_W    = $clog2(FRAC_BITS + 1);
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 72;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [FREQ_W-1:0]  FREQ_ONE  = FREQ_W'(1) << FRAC_BITS;
    localparam logic [STEP_W-1:0]  STEP_LAST = STEP_W'(FRAC_BITS);

    // genotype codes
    localparam logic [GENO_W-1:0] GENO_HOM_REF = 3'd0;
    localparam logic [GENO_W-1:0] GENO_HET     = 3'd1;
    localparam logic [GENO_W-1:0] GENO_HOM_ALT = 3'd2;
    localparam logic [GENO_W-1:0] GENO_MISSING = 3'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL,
        ST_ACC,
        ST_DONE
    } gaf_state_t;

endpackage

`default_nettype wire

@@ design/genotype_allele_frequency_core.sv @@
// top level: per-column allele frequencies and running sum of 2pq
// a column-end beat passes through two 17-step divisions on one shared
//   subtract/compare unit, one multiply, one accumulate and one output load
// input: samples that do not end a column are taken one per cycle while no
//   column is in progress; a column-end beat holds the input side until its
//   result is loaded into the output register
// reset: rst_n asynchronous, active low; clears counts, accumulator and valid
`default_nettype none

module genotype_allele_frequency_core
    import gaf_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,   // genotype[2:0], zeros
    input  wire logic                  s_axis_tlast,   // column_end
    input  wire logic                  s_axis_tuser,   // matrix_end
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,   // ref_freq, alt_freq, two_pq_sum, zeros
    output logic                       m_axis_tlast    // final_column
);

    // control state
    gaf_state_t          state_reg, state_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic                sel_reg, sel_next;
    logic                out_valid_reg, out_valid_next;

    // per-column counters
    logic [COUNT_W-1:0]  hom_ref_reg, het_reg, hom_alt_reg, obs_reg;
    logic [COUNT_W-1:0]  hom_ref_next, het_next, hom_alt_next, obs_next;
    logic [ACC_W-1:0]    acc_reg, acc_next;

    // column snapshot and divider state
    logic [NUM_W-1:0]    num0_reg, num2_reg;
    logic [DEN_W-1:0]    den_reg;
    logic                zero_reg;
    logic                final_reg;
    logic [DEN_W-1:0]    rem_reg;
    logic [FREQ_W-1:0]   quo_reg;
    logic [FREQ_W-1:0]   p0_reg, p2_reg;
    logic [PROD_W-1:0]   prod_reg;

    // output register
    logic [FREQ_W-1:0]   ref_freq_reg, alt_freq_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic                last_reg;

    // decoded strobes
    logic                accept;
    logic                col_accept;
    logic                div_run;
    logic                load_out;

    logic [GENO_W-1:0]   genotype;
    logic [NUM_W-1:0]    num0_new, num2_new;

    // shared divide unit
    logic [NUM_W-1:0]    div_a;
    logic [NUM_W:0]      div_diff;
    logic                div_bit;
    logic [DEN_W-1:0]    div_rem;
    logic [FREQ_W-1:0]   div_quo;
    logic [FREQ_W-1:0]   div_freq;

    logic [TERM_W-1:0]   term;
    logic [ACC_W:0]      acc_sum;
    logic [SUM_W-1:0]    sum_clamped;

    assign genotype   = s_axis_tdata[GENO_W-1:0];
    assign accept     = s_axis_tvalid && s_axis_tready;
    assign col_accept = accept && s_axis_tlast;

    // ------------------------------------------------------------------
    // counters: saturating, cleared once a column is snapshot
    // ------------------------------------------------------------------
    always_comb
    begin
        hom_ref_next = hom_ref_reg;
        het_next     = het_reg;
        hom_alt_next = hom_alt_reg;
        obs_next     = obs_reg;
        if (genotype != GENO_MISSING)
        begin
            if (obs_reg != COUNT_MAX)
                obs_next = obs_reg + 1'b1;
            if (genotype == GENO_HOM_REF && hom_ref_reg != COUNT_MAX)
                hom_ref_next = hom_ref_reg + 1'b1;
            if (genotype == GENO_HET && het_reg != COUNT_MAX)
                het_next = het_reg + 1'b1;
            if (genotype == GENO_HOM_ALT && hom_alt_reg != COUNT_MAX)
                hom_alt_next = hom_alt_reg + 1'b1;
        end
    end

    // numerators 2*c0+c1 and 2*c2+c1 of the closing column
    assign num0_new = {1'b0, hom_ref_next, 1'b0} + {2'b00, het_next};
    assign num2_new = {1'b0, hom_alt_next, 1'b0} + {2'b00, het_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hom_ref_reg <= '0;
            het_reg     <= '0;
            hom_alt_reg <= '0;
            obs_reg     <= '0;
        end
        else if (accept)
        begin
            if (s_axis_tlast)
            begin
                hom_ref_reg <= '0;
                het_reg     <= '0;
                hom_alt_reg <= '0;
                obs_reg     <= '0;
            end
            else
            begin
                hom_ref_reg <= hom_ref_next;
                het_reg     <= het_next;
                hom_alt_reg <= hom_alt_next;
                obs_reg     <= obs_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // shared restoring divide step: one quotient bit per cycle
    // the numerator never reaches twice the divisor, so the first step
    // yields the integer bit and the rest the fraction bits
    // ------------------------------------------------------------------
    assign div_a    = (step_reg == '0) ? (sel_reg ? num2_reg : num0_reg)
                                       : {rem_reg, 1'b0};
    assign div_diff = {1'b0, div_a} - {2'b00, den_reg};
    assign div_bit  = !div_diff[NUM_W];
    assign div_rem  = div_bit ? div_diff[DEN_W-1:0] : div_a[DEN_W-1:0];
    assign div_quo  = {quo_reg[FREQ_W-2:0], div_bit};

    always_comb
    begin
        if (zero_reg)
            div_freq = '0;
        else if (div_quo > FREQ_ONE)
            div_freq = FREQ_ONE;
        else
            div_freq = div_quo;
    end

    // term = floor(2*p0*p2 / 2^FRAC_BITS)
    assign term    = prod_reg[PROD_W-1:FRAC_BITS-1];
    assign acc_sum = {1'b0, acc_reg} + {{(ACC_W+1-TERM_W){1'b0}}, term};

    always_comb
    begin
        if (acc_reg[ACC_W-1:SUM_W] != '0)
            sum_clamped = '1;
        else
            sum_clamped = acc_reg[SUM_W-1:0];
    end

    // ------------------------------------------------------------------
    // sequencer: next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        sel_next   = sel_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (col_accept)
                begin
                    state_next = ST_DIV;
                    step_next  = '0;
                    sel_next   = 1'b0;
                end
            end
            ST_DIV:
            begin
                if (step_reg == STEP_LAST)
                begin
                    step_next = '0;
                    if (sel_reg)
                        state_next = ST_MUL;
                    else
                        sel_next = 1'b1;
                end
                else
                    step_next = step_reg + 1'b1;
            end
            ST_MUL:
                state_next = ST_ACC;
            ST_ACC:
                state_next = ST_DONE;
            ST_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // sequencer: outputs
    always_comb
    begin
        s_axis_tready = 1'b0;
        div_run       = 1'b0;
        load_out      = 1'b0;
        unique case (state_reg)
            ST_IDLE: s_axis_tready = 1'b1;
            ST_DIV:  div_run = 1'b1;
            ST_MUL:  ;
            ST_ACC:  ;
            ST_DONE: load_out = !out_valid_reg || m_axis_tready;
            default: ;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_comb
    begin
        acc_next = acc_reg;
        if (state_reg == ST_ACC)
            acc_next = acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];
        else if (load_out && final_reg)
            acc_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            sel_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            acc_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            sel_reg       <= sel_next;
            out_valid_reg <= out_valid_next;
            acc_reg       <= acc_next;
        end
    end

    // ------------------------------------------------------------------
    // datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (col_accept)
        begin
            num0_reg  <= num0_new;
            num2_reg  <= num2_new;
            den_reg   <= {obs_next, 1'b0};
            zero_reg  <= (obs_next == '0);
            final_reg <= s_axis_tuser;
        end
        if (div_run)
        begin
            rem_reg <= div_rem;
            quo_reg <= div_quo;
            if (step_reg == STEP_LAST)
            begin
                if (sel_reg)
                    p2_reg <= div_freq;
                else
                    p0_reg <= div_freq;
            end
        end
        if (state_reg == ST_MUL)
            prod_reg <= p0_reg * p2_reg;
        if (load_out)
        begin
            ref_freq_reg <= p0_reg;
            alt_freq_reg <= p2_reg;
            sum_reg      <= sum_clamped;
            last_reg     <= final_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W-2*FREQ_W-SUM_W){1'b0}},
                            sum_reg, alt_freq_reg, ref_freq_reg};
    assign m_axis_tlast  = last_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && step_reg != '0 && !zero_reg) |-> (rem_reg < den_reg))
        else $error("divider remainder not below divisor");

    a_freq_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (ref_freq_reg <= FREQ_ONE && alt_freq_reg <= FREQ_ONE))
        else $error("frequency above one");

    a_acc_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && final_reg) |=> (acc_reg == '0))
        else $error("accumulator not cleared after final column");

    a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV || state_reg == ST_MUL) |-> !s_axis_tready)
        else $error("input taken while a column is in progress");

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// testbench for genotype_allele_frequency_core: per-column frequency and 2pq sum checks
`timescale 1ns / 100ps

module testbench
    import gaf_pkg::*;
();

    // codes above the missing code that still count as observed
    localparam logic [GENO_W-1:0] GENO_OTHER = 3'd4;
    localparam int GENO_CODES = 2 ** GENO_W;
    localparam int DRAIN_CYCLES = 40;
    localparam int RANDOM_SAMPLES = 700;

    typedef struct packed {
        logic [FREQ_W-1:0] ref_freq;
        logic [FREQ_W-1:0] alt_freq;
        logic [SUM_W-1:0]  two_pq_sum;
        logic              final_column;
    } column_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  s_axis_tlast = 1'b0;
    logic                  s_axis_tuser = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;

    // predicted per-column state
    logic [COUNT_W-1:0] hom_ref_tally;
    logic [COUNT_W-1:0] het_tally;
    logic [COUNT_W-1:0] hom_alt_tally;
    logic [COUNT_W-1:0] observed_tally;
    logic [ACC_W-1:0]   two_pq_total;

    column_result_t expected_columns[$];
    int unsigned    error_count = 0;
    bit             quiet = 1'b0;   // no gaps and no stalls while set
    int unsigned    sink_stall = 0;

    genotype_allele_frequency_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [COUNT_W-1:0] bump(input logic [COUNT_W-1:0] c);
        return (c == COUNT_MAX) ? c : c + 1'b1;
    endfunction

    // truncated ratio with FRAC_BITS fraction bits, clamped to one
    function automatic logic [FREQ_W-1:0] allele_freq(input logic [63:0] num,
                                                      input logic [63:0] nobs);
        logic [63:0] q;
        if (nobs == 0)
            return '0;
        q = (num << FRAC_BITS) / (2 * nobs);
        return (q > FREQ_ONE) ? FREQ_ONE : q[FREQ_W-1:0];
    endfunction

    function automatic void clear_tallies();
        hom_ref_tally  = '0;
        het_tally      = '0;
        hom_alt_tally  = '0;
        observed_tally = '0;
    endfunction

    // update tallies for one accepted beat, queue a column result on column end
    function automatic void account_sample(input logic [GENO_W-1:0] geno,
                                           input logic col_end, input logic mat_end);
        column_result_t r;
        logic [63:0]    term;
        if (geno != GENO_MISSING)
        begin
            observed_tally = bump(observed_tally);
            if (geno == GENO_HOM_REF)
                hom_ref_tally = bump(hom_ref_tally);
            else if (geno == GENO_HET)
                het_tally = bump(het_tally);
            else if (geno == GENO_HOM_ALT)
                hom_alt_tally = bump(hom_alt_tally);
        end
        if (!col_end)
            return;
        r.ref_freq = allele_freq(2 * 64'(hom_ref_tally) + het_tally, observed_tally);
        r.alt_freq = allele_freq(2 * 64'(hom_alt_tally) + het_tally, observed_tally);
        term = (2 * 64'(r.ref_freq) * 64'(r.alt_freq)) >> FRAC_BITS;
        if (two_pq_total > ~64'd0 - term)
            two_pq_total = ~64'd0;
        else
            two_pq_total = two_pq_total + term;
        r.two_pq_sum   = (two_pq_total > 64'hFFFF_FFFF) ? '1 : two_pq_total[SUM_W-1:0];
        r.final_column = mat_end;
        expected_columns.push_back(r);
        clear_tallies();
        if (mat_end)
            two_pq_total = '0;
    endfunction

    // result side: random back-pressure per beat
    always @(posedge clk)
    begin
        int unsigned stall;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            sink_stall    <= 0;
        end
        else if (m_axis_tvalid && m_axis_tready)
        begin
            stall = quiet ? 0 : $urandom_range(0, 3);
            sink_stall    <= stall;
            m_axis_tready <= (stall == 0);
        end
        else if (sink_stall > 1)
        begin
            sink_stall    <= sink_stall - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            sink_stall    <= 0;
            m_axis_tready <= 1'b1;
        end
    end

    // compare every accepted result beat against the oldest prediction
    always @(posedge clk)
    begin
        column_result_t exp_r;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_columns.size() == 0)
            begin
                $error("unexpected result beat: tdata %h tlast %b", m_axis_tdata, m_axis_tlast);
                error_count++;
            end
            else
            begin
                exp_r = expected_columns.pop_front();
                if (m_axis_tdata[FREQ_W-1:0] !== exp_r.ref_freq)
                begin
                    $error("ref_freq: expected %0d, got %0d",
                           exp_r.ref_freq, m_axis_tdata[FREQ_W-1:0]);
                    error_count++;
                end
                if (m_axis_tdata[2*FREQ_W-1:FREQ_W] !== exp_r.alt_freq)
                begin
                    $error("alt_freq: expected %0d, got %0d",
                           exp_r.alt_freq, m_axis_tdata[2*FREQ_W-1:FREQ_W]);
                    error_count++;
                end
                if (m_axis_tdata[2*FREQ_W+SUM_W-1:2*FREQ_W] !== exp_r.two_pq_sum)
                begin
                    $error("two_pq_sum: expected %0d, got %0d",
                           exp_r.two_pq_sum, m_axis_tdata[2*FREQ_W+SUM_W-1:2*FREQ_W]);
                    error_count++;
                end
                if (m_axis_tlast !== exp_r.final_column)
                begin
                    $error("final_column: expected %0d, got %0d",
                           exp_r.final_column, m_axis_tlast);
                    error_count++;
                end
            end
        end
    end

    // one sample beat; returns at the edge where it is accepted
    task automatic send_sample(input logic [GENO_W-1:0] geno, input logic col_end,
                               input logic mat_end);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 3);
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_DATA_W'(geno);
        s_axis_tlast  <= col_end;
        s_axis_tuser  <= mat_end;
        do
            @(posedge clk);
        while (!s_axis_tready);
        account_sample(geno, col_end, mat_end);
    endtask

    // hold the source until every predicted column has come out
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        while (expected_columns.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic test_directed_columns();
        // single-sample columns, one per genotype class
        send_sample(GENO_HOM_REF, 1'b1, 1'b0);
        send_sample(GENO_HET, 1'b1, 1'b0);
        send_sample(GENO_HOM_ALT, 1'b1, 1'b0);
        // empty column: only missing samples
        send_sample(GENO_MISSING, 1'b0, 1'b0);
        send_sample(GENO_MISSING, 1'b1, 1'b0);
        // het plus every other observed code, none of them in a class
        send_sample(GENO_HET, 1'b0, 1'b0);
        for (int g = GENO_OTHER; g < GENO_CODES; g++)
            send_sample(GENO_W'(g), 1'b0, 1'b0);
        send_sample(GENO_MISSING, 1'b1, 1'b0);
        // matrix end without column end is ignored
        send_sample(GENO_HOM_REF, 1'b0, 1'b1);
        send_sample(GENO_HET, 1'b0, 1'b1);
        send_sample(GENO_HOM_ALT, 1'b1, 1'b1);
        // sum restarts after the closing column
        send_sample(GENO_HET, 1'b0, 1'b0);
        send_sample(GENO_HOM_REF, 1'b1, 1'b1);
        wait_for_results();
    endtask

    function automatic logic [GENO_W-1:0] draw_genotype();
        int unsigned r;
        r = $urandom_range(0, 15);
        if (r < 4)
            return GENO_HOM_REF;
        else if (r < 9)
            return GENO_HET;
        else if (r < 12)
            return GENO_HOM_ALT;
        else if (r < 14)
            return GENO_MISSING;
        return GENO_W'($urandom_range(GENO_OTHER, GENO_CODES - 1));
    endfunction

    task automatic test_random_matrices();
        int unsigned sent;
        int unsigned n_cols;
        int unsigned n_rows;
        bit          empty_col;
        bit          is_last;
        sent = 0;
        while (sent < RANDOM_SAMPLES)
        begin
            // some matrices run flat out on both sides
            quiet  = ($urandom_range(0, 3) == 0);
            n_cols = $urandom_range(1, 8);
            for (int c = 0; c < n_cols; c++)
            begin
                n_rows    = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120)
                                                       : $urandom_range(1, 12);
                empty_col = ($urandom_range(0, 14) == 0);
                for (int i = 0; i < n_rows; i++)
                begin
                    is_last = (i == n_rows - 1);
                    send_sample(empty_col ? GENO_MISSING : draw_genotype(), is_last,
                                is_last ? (c == n_cols - 1)
                                        : ($urandom_range(0, 9) == 0));
                    sent++;
                end
            end
            if ($urandom_range(0, 3) == 0)
                wait_for_results();
        end
        quiet = 1'b0;
        wait_for_results();
    endtask

    initial
    begin
        clear_tallies();
        two_pq_total = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_columns();
        test_random_matrices();
        wait_for_results();
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

@@ genotype_allele_frequency_core.f @@
design/gaf_pkg.sv
design/genotype_allele_frequency_core.sv
tb/testbench.sv
